// ----- src/ambgs_pkg.sv -----
`timescale 1ns / 1ps
package ambgs_pkg;

	localparam int MAX_PIXELS = 1048576;
	localparam int IDX_W      = $clog2(MAX_PIXELS);
	localparam int SIZE_W     = IDX_W + 1;
	localparam int DIM_W      = 11;
	localparam int DIM_MAX    = 1024;
	localparam int CHAN_W     = 8;
	localparam int NUM_CHAN   = 3;
	localparam int BG_W       = NUM_CHAN * CHAN_W;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(480);
	localparam logic [SIZE_W-1:0] SIZE_RESET   = SIZE_W'(640 * 480);

	typedef logic [CHAN_W-1:0] chan_t;

	typedef struct packed {
		chan_t red_in;
		chan_t green_in;
		chan_t blue_in;
	} pixel_t;

	typedef struct packed {
		chan_t red_diff;
		chan_t green_diff;
		chan_t blue_diff;
		logic  frame_end;
	} result_t;

	typedef struct packed {
		logic [SIZE_W-1:0] frame_size;
	} frame_cfg_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(DIM_MAX)) begin
			r = DIM_W'(DIM_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [SIZE_W-1:0] calc_frame_size(input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		logic [2*DIM_W-1:0] n;
		logic [SIZE_W-1:0]  r;
		n = {{DIM_W{1'b0}}, clamp_dim(w)} * {{DIM_W{1'b0}}, clamp_dim(h)};
		if (n > (2*DIM_W)'(MAX_PIXELS)) begin
			r = SIZE_W'(MAX_PIXELS);
		end else begin
			r = n[SIZE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- src/ambgs_ram.sv -----
`timescale 1ns / 1ps
module ambgs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/ambgs_lane.sv -----
`timescale 1ns / 1ps
module ambgs_lane (
	input  ambgs_pkg::chan_t bg,
	input  ambgs_pkg::chan_t x,
	input  logic             loaded,
	output ambgs_pkg::chan_t new_bg,
	output ambgs_pkg::chan_t diff
);
	import ambgs_pkg::*;

	chan_t base;

	always_comb begin
		base = loaded ? bg : x;
		if (base < x) begin
			new_bg = base + CHAN_W'(1);
		end else if (base > x) begin
			new_bg = base - CHAN_W'(1);
		end else begin
			new_bg = base;
		end
		diff = (x >= new_bg) ? (x - new_bg) : (new_bg - x);
	end

endmodule

// ----- src/ambgs_cfg.sv -----
`timescale 1ns / 1ps
module ambgs_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ambgs_pkg::PADDR_W-1:0]         paddr,
	input  logic [ambgs_pkg::PDATA_W-1:0]         pwdata,
	output logic [ambgs_pkg::PDATA_W-1:0]         prdata,
	output logic                                  pready,
	output ambgs_pkg::frame_cfg_t                 cfg
);
	import ambgs_pkg::*;

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [SIZE_W-1:0] size_q;
	logic              wr_en;
	logic [DIM_W-1:0]  wr_dim;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign wr_dim = pwdata[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			size_q   <= SIZE_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_FRAME_WIDTH: begin
					width_q <= wr_dim;
					size_q  <= calc_frame_size(wr_dim, height_q);
				end
				REG_FRAME_HEIGHT: begin
					height_q <= wr_dim;
					size_q   <= calc_frame_size(width_q, wr_dim);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FRAME_WIDTH:  prdata = PDATA_W'(width_q);
			REG_FRAME_HEIGHT: prdata = PDATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.frame_size = size_q;

endmodule

// ----- src/approx_median_background_subtract.sv -----
`timescale 1ns / 1ps
// Approximate-median background subtraction for a raster-order colour pixel stream. The block
// takes one pixel per clock while the output is not stalled and returns one result per pixel.
// Each pixel is registered in stage one with the registered background memory read, and its
// differences in the output register. A pixel that hits the entry its predecessor is still
// writing (single-pixel frames) is served by a bypass that keeps the rate. Three channel lanes
// step the background toward the input and form the absolute differences side by side. During
// the first frame after reset the background is loaded from the input and every difference is
// zero. The background memory holds 2^20 entries of 24 bits and is not cleared: only pixels
// written during an earlier frame may be read. Frame width and height are written through the
// APB port at byte addresses 0 and 4 and should be written only while the stream is idle.
module approx_median_background_subtract (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  ambgs_pkg::pixel_t             pix,
	output logic                          res_valid,
	input  logic                          res_stall,
	output ambgs_pkg::result_t            res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ambgs_pkg::PADDR_W-1:0] paddr,
	input  logic [ambgs_pkg::PDATA_W-1:0] pwdata,
	output logic [ambgs_pkg::PDATA_W-1:0] prdata,
	output logic                          pready
);
	import ambgs_pkg::*;

	frame_cfg_t        cfg;
	logic              accept;
	logic              adv;
	logic              last;
	logic [IDX_W-1:0]  idx_q;
	logic              loaded_q;
	logic              valid_s1;
	pixel_t            pix_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              last_s1;
	logic              loaded_s1;
	logic              fwd_s1;
	logic [BG_W-1:0]   fwd_data_s1;
	logic [BG_W-1:0]   rdata;
	logic [BG_W-1:0]   bg_word;
	logic [BG_W-1:0]   new_word;
	chan_t             x_chan    [NUM_CHAN];
	chan_t             diff_chan [NUM_CHAN];
	logic              res_valid_q;
	result_t           res_q;

	ambgs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv       = valid_s1 & (~res_valid_q | ~res_stall);
	assign pix_stall = valid_s1 & ~adv;
	assign accept    = pix_valid & ~pix_stall;
	assign last      = ({1'b0, idx_q} + SIZE_W'(1)) >= cfg.frame_size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			loaded_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				idx_q    <= '0;
				loaded_q <= 1'b1;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pix;
			idx_s1      <= idx_q;
			last_s1     <= last;
			loaded_s1   <= loaded_q;
			fwd_s1      <= adv && (idx_s1 == idx_q);
			fwd_data_s1 <= new_word;
		end
	end

	ambgs_ram #(
		.WIDTH (BG_W),
		.DEPTH (MAX_PIXELS)
	) u_bg_ram (
		.clk   (clk),
		.we    (adv),
		.waddr (idx_s1),
		.wdata (new_word),
		.re    (accept),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign bg_word   = fwd_s1 ? fwd_data_s1 : rdata;
	assign x_chan[0] = pix_s1.red_in;
	assign x_chan[1] = pix_s1.green_in;
	assign x_chan[2] = pix_s1.blue_in;

	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
		ambgs_lane u_lane (
			.bg     (bg_word[c*CHAN_W +: CHAN_W]),
			.x      (x_chan[c]),
			.loaded (loaded_s1),
			.new_bg (new_word[c*CHAN_W +: CHAN_W]),
			.diff   (diff_chan[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.red_diff   <= diff_chan[0];
			res_q.green_diff <= diff_chan[1];
			res_q.blue_diff  <= diff_chan[2];
			res_q.frame_end  <= last_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_hold_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(idx_s1))
		else $error("stage one item changed while it was held");

	a_wrap : assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> idx_q == '0)
		else $error("pixel index did not wrap after the last pixel");

	a_loaded_stays : assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> !$fell(loaded_q))
		else $error("background loaded flag cleared without reset");

	a_first_frame_zero : assert property (@(posedge clk) disable iff (!arst_n)
		adv && !loaded_s1 |=> res_q.red_diff == '0 && res_q.green_diff == '0
			&& res_q.blue_diff == '0)
		else $error("nonzero difference during the loading frame");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import ambgs_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 4;
	localparam int FILL_ITEMS = 400;
	localparam int RANDOM_ITEMS = 1600;
	localparam logic [PADDR_W-1:0] ADDR_WIDTH = {REG_FRAME_WIDTH, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pixel_t pix = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	result_t res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	logic [DIM_W-1:0] cfg_width = WIDTH_RESET;
	logic [DIM_W-1:0] cfg_height = HEIGHT_RESET;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] background [int];
	bit bg_loaded = 1'b0;
	int pix_idx = 0;
	int written_count = 0;
	result_t expected_diffs [$];

	int mismatches = 0;
	int unsigned cycle_count = 0;
	bit src_quiet = 1'b0;
	bit sink_quiet = 1'b0;
	int sink_wait = 0;

	approx_median_background_subtract dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int frame_pixels(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		int cw;
		int ch;
		int n;
		cw = (w == 0) ? 1 : ((w > DIM_MAX) ? DIM_MAX : int'(w));
		ch = (h == 0) ? 1 : ((h > DIM_MAX) ? DIM_MAX : int'(h));
		n = cw * ch;
		if (n > MAX_PIXELS) begin
			n = MAX_PIXELS;
		end
		return n;
	endfunction

	function automatic result_t predict_diff(input pixel_t p);
		logic [NUM_CHAN-1:0][CHAN_W-1:0] x;
		logic [NUM_CHAN-1:0][CHAN_W-1:0] b;
		logic [NUM_CHAN-1:0][CHAN_W-1:0] d;
		result_t r;
		int sz;
		sz = frame_pixels(cfg_width, cfg_height);
		x = {p.blue_in, p.green_in, p.red_in};
		b = bg_loaded ? background[pix_idx] : x;
		for (int c = 0; c < NUM_CHAN; c++) begin
			if (b[c] < x[c]) begin
				b[c] = b[c] + 8'd1;
			end else if (b[c] > x[c]) begin
				b[c] = b[c] - 8'd1;
			end
			d[c] = (x[c] >= b[c]) ? x[c] - b[c] : b[c] - x[c];
		end
		background[pix_idx] = b;
		if (pix_idx + 1 > written_count) begin
			written_count = pix_idx + 1;
		end
		r.red_diff = d[0];
		r.green_diff = d[1];
		r.blue_diff = d[2];
		r.frame_end = (pix_idx + 1 >= sz);
		if (r.frame_end) begin
			pix_idx = 0;
			bg_loaded = 1'b1;
		end else begin
			pix_idx = pix_idx + 1;
		end
		return r;
	endfunction

	function automatic pixel_t pixel_near(input int delta);
		logic [NUM_CHAN-1:0][CHAN_W-1:0] b;
		pixel_t p;
		b = background[pix_idx];
		p.red_in = CHAN_W'(int'(b[0]) + delta);
		p.green_in = CHAN_W'(int'(b[1]) + delta);
		p.blue_in = CHAN_W'(int'(b[2]) + delta);
		return p;
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		case ($urandom_range(0, 3))
			0: begin
				p = pixel_t'($urandom());
			end
			1: begin
				p.red_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.blue_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: begin
				if (bg_loaded) begin
					p = pixel_near(int'($urandom_range(0, 4)) - 2);
				end else begin
					p = pixel_t'($urandom());
				end
			end
		endcase
		return p;
	endfunction

	function automatic int next_wait(input bit quiet);
		return quiet ? 0 : int'($urandom_range(0, 14));
	endfunction

	function automatic int pick_dim();
		int v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 1;
			2: v = $urandom_range(DIM_MAX + 1, 2047);
			3: v = $urandom_range(1, written_count);
			default: v = $urandom_range(2, 24);
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= 100) begin
			$display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (expected_diffs.size() == 0) begin
			report_mismatch("unexpected result", got, 0);
			return;
		end
		want = expected_diffs.pop_front();
		if (got.red_diff !== want.red_diff) begin
			report_mismatch("red_diff", got.red_diff, want.red_diff);
		end
		if (got.green_diff !== want.green_diff) begin
			report_mismatch("green_diff", got.green_diff, want.green_diff);
		end
		if (got.blue_diff !== want.blue_diff) begin
			report_mismatch("blue_diff", got.blue_diff, want.blue_diff);
		end
		if (got.frame_end !== want.frame_end) begin
			report_mismatch("frame_end", got.frame_end, want.frame_end);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				check_result(res);
				if ($urandom_range(0, 31) == 0) begin
					sink_quiet = !sink_quiet;
				end
				sink_wait = next_wait(sink_quiet);
				res_stall <= (sink_wait != 0);
			end else if (sink_wait > 0) begin
				sink_wait = sink_wait - 1;
				res_stall <= (sink_wait != 0);
			end
		end
	end

	task automatic send_pixel(input pixel_t p);
		int gap;
		if ($urandom_range(0, 31) == 0) begin
			src_quiet = !src_quiet;
		end
		gap = next_wait(src_quiet);
		if (gap != 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		do @(posedge clk); while (pix_stall);
		expected_diffs.push_back(predict_diff(p));
	endtask

	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_WIDTH) begin
			cfg_width = data[DIM_W-1:0];
		end else if (addr == ADDR_HEIGHT) begin
			cfg_height = data[DIM_W-1:0];
		end
		@(posedge clk);
	endtask

	task automatic check_register(input logic [PADDR_W-1:0] addr, input logic [DIM_W-1:0] want);
		logic [PDATA_W-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== PDATA_W'(want)) begin
			report_mismatch("register read", got, want);
		end
	endtask

	task automatic wait_idle();
		pix_valid <= 1'b0;
		while (expected_diffs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_register_access();
		check_register(ADDR_WIDTH, WIDTH_RESET);
		check_register(ADDR_HEIGHT, HEIGHT_RESET);
		reg_write(ADDR_WIDTH, 32'hFFFF_FFFF);
		reg_write(ADDR_HEIGHT, PDATA_W'(DIM_MAX));
		check_register(ADDR_WIDTH, cfg_width);
		check_register(ADDR_HEIGHT, cfg_height);
	endtask

	task automatic test_first_frame_load();
		send_pixel(pixel_t'(24'h000000));
		send_pixel(pixel_t'(24'hFFFFFF));
		send_pixel(pixel_t'(24'hAA55AA));
		send_pixel(pixel_t'(24'h55AA55));
		send_pixel(pixel_t'(24'h0180FE));
		send_pixel(pixel_t'(24'hFE7F01));
		send_pixel(pixel_t'(24'h00FF00));
		send_pixel(pixel_t'(24'hFF00FF));
		repeat (FILL_ITEMS) send_pixel(rand_pixel());
		wait_idle();
	endtask

	task automatic test_mid_frame_resize();
		reg_write(ADDR_WIDTH, '0);
		reg_write(ADDR_HEIGHT, '0);
		check_register(ADDR_WIDTH, cfg_width);
		check_register(ADDR_HEIGHT, cfg_height);
		send_pixel(pixel_t'(24'h123456));
		send_pixel(pixel_t'(24'hFFFFFF));
		send_pixel(pixel_t'(24'h000000));
		wait_idle();
	endtask

	task automatic test_background_step();
		reg_write(ADDR_WIDTH, 32'd8);
		reg_write(ADDR_HEIGHT, 32'd1);
		send_pixel(pixel_near(0));
		send_pixel(pixel_near(1));
		send_pixel(pixel_near(-1));
		send_pixel(pixel_near(128));
		send_pixel(pixel_t'(24'h000000));
		send_pixel(pixel_t'(24'hFFFFFF));
		send_pixel(pixel_t'(24'h00FF00));
		send_pixel(pixel_t'(24'hFF00FF));
		wait_idle();
	endtask

	task automatic test_random_frames();
		int sent;
		int w;
		int h;
		int which;
		int burst;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			which = $urandom_range(0, 2);
			do begin
				w = (which == 1) ? int'(cfg_width) : pick_dim();
				h = (which == 0) ? int'(cfg_height) : pick_dim();
			end while (frame_pixels(DIM_W'(w), DIM_W'(h)) > written_count);
			if (which != 1) begin
				reg_write(ADDR_WIDTH, {21'($urandom()), DIM_W'(w)});
			end
			if (which != 0) begin
				reg_write(ADDR_HEIGHT, {21'($urandom()), DIM_W'(h)});
			end
			check_register(ADDR_WIDTH, cfg_width);
			check_register(ADDR_HEIGHT, cfg_height);
			burst = 3 * frame_pixels(cfg_width, cfg_height);
			burst = $urandom_range(1, (burst > 200) ? 200 : burst);
			repeat (burst) begin
				send_pixel(rand_pixel());
				sent++;
			end
			wait_idle();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_first_frame_load();
		test_mid_frame_resize();
		test_background_step();
		test_random_frames();
		if (expected_diffs.size() != 0) begin
			report_mismatch("results missing", 0, expected_diffs.size());
		end
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/ambgs_pkg.sv
src/ambgs_ram.sv
src/ambgs_lane.sv
src/ambgs_cfg.sv
src/approx_median_background_subtract.sv
tb/tb_top.sv
